[hdl/cht_pkg.sv]
// Shared types and constants for the coalesced hash table insert unit.
// No dependencies; every other file but cht_ram imports this package.
`timescale 1ns / 1ps
package cht_pkg;

  localparam int SLOTS      = 256;
  localparam int KEY_BYTES  = 8;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int VAL_W      = 32;
  localparam int KIND_W     = 4;
  localparam int HASH_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int SLOT_OUT_W = 8;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_LINK = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]  key_bytes;
    logic [LEN_W-1:0]  key_length;
    logic [VAL_W-1:0]  value_data;
    logic [KIND_W-1:0] value_kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  replaced;
  } out_item_t;

  // Classified insert handed from the front end to the back end
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  value;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  home;
  } job_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  value;
    logic [KIND_W-1:0] kind;
  } data_t;

  typedef struct packed {
    logic             has_link;
    logic [IDX_W-1:0] link;
  } link_t;

endpackage

[hdl/cht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/cht_front.sv]
// Front end: accepts an insert, masks the key, runs the byte-serial hash
// and the 2-bit-per-cycle modulo, then pushes the job. Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  cht_pkg::in_item_t       in_data,
  input  logic [cht_pkg::CNT_W-1:0] size,
  input  logic                    q_full,
  output logic                    busy,
  output logic                    q_push,
  output cht_pkg::job_t           q_job
);
  import cht_pkg::*;

  localparam int MOD_STEPS = HASH_W / 2;
  localparam int MCNT_W    = $clog2(MOD_STEPS);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_HASH = 3'd1;
  localparam logic [2:0] F_FIN  = 3'd2;
  localparam logic [2:0] F_MOD  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  kshift_r, kshift_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        fin_r, fin_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  logic [LEN_W-1:0]  len_c;
  logic [KEY_W-1:0]  key_c;
  logic [HASH_W-1:0] b_ext, t1, t2, t3;
  logic [CNT_W-1:0]  rem_a;

  function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] rem,
                                                input logic bin,
                                                input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    t = {rem, bin};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[CNT_W-1:0];
  endfunction

  always_comb begin
    len_c = (in_data.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                     : in_data.key_length;
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_c[i*8 +: 8] = (i < KEY_BYTES && LEN_W'(i) < len_c) ? in_data.key_bytes[i*8 +: 8]
                                                             : 8'h00;
    end
  end

  // One hash round on the low byte of the shift register, and the modulo step on the top hash bit
  always_comb begin
    b_ext = {{(HASH_W-8){kshift_r[7]}}, kshift_r[7:0]};
    t1    = hash_r + b_ext;
    t2    = t1 + (t1 << 10);
    t3    = t2 ^ (t2 >> 6);
    rem_a = mod_step(rem_r, hash_r[HASH_W-1], size);
  end

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    kshift_nxt = kshift_r;
    len_nxt    = len_r;
    val_nxt    = val_r;
    kind_nxt   = kind_r;
    hash_nxt   = hash_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    mcnt_nxt   = mcnt_r;
    rem_nxt    = rem_r;
    q_push     = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          key_nxt    = key_c;
          kshift_nxt = key_c;
          len_nxt    = len_c;
          val_nxt    = in_data.value_data;
          kind_nxt   = in_data.value_kind;
          hash_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_r == len_r) begin
          fin_nxt   = '0;
          state_nxt = F_FIN;
        end else begin
          hash_nxt   = t3;
          kshift_nxt = kshift_r >> 8;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      F_FIN: begin
        case (fin_r)
          2'd0:    hash_nxt = hash_r + (hash_r << 3);
          2'd1:    hash_nxt = hash_r ^ (hash_r >> 11);
          default: hash_nxt = hash_r + (hash_r << 15);
        endcase
        fin_nxt = fin_r + 1'b1;
        if (fin_r == 2'd2) begin
          rem_nxt   = '0;
          mcnt_nxt  = '0;
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        rem_nxt  = mod_step(rem_a, hash_r[HASH_W-2], size);
        hash_nxt = hash_r << 2;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(MOD_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_push = 1'b1;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    key_r    <= key_nxt;
    kshift_r <= kshift_nxt;
    len_r    <= len_nxt;
    val_r    <= val_nxt;
    kind_r   <= kind_nxt;
    hash_r   <= hash_nxt;
    cnt_r    <= cnt_nxt;
    fin_r    <= fin_nxt;
    mcnt_r   <= mcnt_nxt;
    rem_r    <= rem_nxt;
  end

  assign busy        = (state_r != F_IDLE);
  assign q_job.key   = key_r;
  assign q_job.len   = len_r;
  assign q_job.value = val_r;
  assign q_job.kind  = kind_r;
  assign q_job.home  = rem_r[IDX_W-1:0];

endmodule

[hdl/cht_queue.sv]
// Short job queue between front and back end.
// Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cht_pkg::job_t wr_data,
  output logic          full,
  output logic          rd_valid,
  input  logic          rd_en,
  output cht_pkg::job_t rd_data
);
  import cht_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push, pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_en && !full;
  assign pop      = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

[hdl/cht_back.sv]
// Back end: checks capacity, inserts at home, walks chains, links new
// entries and advances the free pointer. Depends on cht_pkg and cht_ram.
`timescale 1ns / 1ps
module cht_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cht_pkg::CNT_W-1:0] size,
  input  logic                      q_valid,
  input  cht_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      out_valid,
  output cht_pkg::out_item_t        out_data
);
  import cht_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CMP  = 3'd1;
  localparam logic [2:0] B_LINK = 3'd2;
  localparam logic [2:0] B_ADV  = 3'd3;

  logic [2:0]       state_r, state_nxt;
  logic [SLOTS-1:0] used_r;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  job_t             job_r, job_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;

  logic             used_set;
  logic [IDX_W-1:0] used_addr;
  logic [IDX_W-1:0] raddr, end_slot;
  logic             d_we, l_we;
  logic [IDX_W-1:0] d_waddr, l_waddr;
  data_t            d_wdata, d_rd;
  link_t            l_wdata, l_rd;
  logic [$bits(data_t)-1:0] d_rdata;
  logic [$bits(link_t)-1:0] l_rdata;
  logic             match;

  cht_ram #(.WIDTH($bits(data_t)), .DEPTH(SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (raddr),
    .rdata (d_rdata)
  );

  cht_ram #(.WIDTH($bits(link_t)), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  assign d_rd  = data_t'(d_rdata);
  assign l_rd  = link_t'(l_rdata);
  assign match = (d_rd.len == job_r.len) && (d_rd.key == job_r.key);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    free_nxt  = free_r;
    slot_nxt  = slot_r;
    job_nxt   = job_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    used_set  = 1'b0;
    used_addr = job_r.home;
    q_pop     = 1'b0;
    raddr     = cur_r;
    end_slot  = cur_r;
    d_we      = 1'b0;
    d_waddr   = cur_r;
    d_wdata   = '{key: job_r.key, len: job_r.len, value: job_r.value, kind: job_r.kind};
    l_we      = 1'b0;
    l_waddr   = cur_r;
    l_wdata   = '0;
    case (state_r)
      B_IDLE: begin
        raddr = q_job.home;
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          if (count_r >= size) begin
            ov_nxt = 1'b1;
            od_nxt = '{status: ST_FULL, slot_index: '0, replaced: 1'b0};
          end else if (!used_r[q_job.home]) begin
            d_we      = 1'b1;
            d_waddr   = q_job.home;
            d_wdata   = '{key: q_job.key, len: q_job.len, value: q_job.value,
                          kind: q_job.kind};
            l_we      = 1'b1;
            l_waddr   = q_job.home;
            used_set  = 1'b1;
            used_addr = q_job.home;
            count_nxt = count_r + 1'b1;
            if (CNT_W'(q_job.home) == free_r) begin
              slot_nxt  = q_job.home;
              state_nxt = B_ADV;
            end else begin
              ov_nxt = 1'b1;
              od_nxt = '{status: ST_OK, slot_index: SLOT_OUT_W'(q_job.home),
                         replaced: 1'b0};
            end
          end else begin
            cur_nxt   = q_job.home;
            steps_nxt = '0;
            state_nxt = B_CMP;
          end
        end
      end
      B_CMP: begin
        raddr = l_rd.link;
        if (match) begin
          d_we      = 1'b1;
          ov_nxt    = 1'b1;
          od_nxt    = '{status: ST_OK, slot_index: SLOT_OUT_W'(cur_r), replaced: 1'b1};
          state_nxt = B_IDLE;
        end else if (l_rd.has_link && steps_r != IDX_W'(SLOTS - 1)) begin
          cur_nxt   = l_rd.link;
          steps_nxt = steps_r + 1'b1;
        end else begin
          // a walk cut off at the step limit ends on the slot it was sent to
          end_slot = l_rd.has_link ? l_rd.link : cur_r;
          if (free_r >= size) begin
            ov_nxt    = 1'b1;
            od_nxt    = '{status: ST_NO_LINK, slot_index: '0, replaced: 1'b0};
            state_nxt = B_IDLE;
          end else begin
            l_we      = 1'b1;
            l_waddr   = end_slot;
            l_wdata   = '{has_link: 1'b1, link: free_r[IDX_W-1:0]};
            state_nxt = B_LINK;
          end
        end
      end
      B_LINK: begin
        d_we      = 1'b1;
        d_waddr   = free_r[IDX_W-1:0];
        l_we      = 1'b1;
        l_waddr   = free_r[IDX_W-1:0];
        used_set  = 1'b1;
        used_addr = free_r[IDX_W-1:0];
        count_nxt = count_r + 1'b1;
        slot_nxt  = free_r[IDX_W-1:0];
        state_nxt = B_ADV;
      end
      B_ADV: begin
        // advance past used slots, stop at the table size
        if (free_r < size && used_r[free_r[IDX_W-1:0]]) begin
          free_nxt = free_r + 1'b1;
        end else begin
          ov_nxt    = 1'b1;
          od_nxt    = '{status: ST_OK, slot_index: SLOT_OUT_W'(slot_r), replaced: 1'b0};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      used_r  <= '0;
      count_r <= '0;
      free_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      ov_r    <= ov_nxt;
      if (used_set) begin
        used_r[used_addr] <= 1'b1;
      end
    end
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    slot_r  <= slot_nxt;
    job_r   <= job_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

[hdl/coalesced_hash_table_insert_unit.sv]
// Top level of the coalesced hash table insert unit: config register,
// front end, job queue and back end. Depends on cht_pkg and all cht_ modules.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------
//   input    | start, busy, in_data           | taken when start && !busy
//   result   | out_valid, out_data            | one-cycle strobe, no stall
//   config   | psel penable pwrite paddr ...  | write on psel&penable&pwrite&!paddr[2]
//
// While busy, the front end hashes the key byte by byte, closes the byte
// loop, applies the three-step final mix, runs the 2-bit-per-cycle modulo
// by the table size and then pushes the job, waiting while the queue is full.
// The back end answers a full table or a home insert from idle, going on to
// the free pointer scan if the home slot was the free slot; a chain walk
// compares entries in turn, then writes a new link and entry before the scan.
// The result strobes on the cycle after the back end finishes.
// Up to two hashed inserts queue ahead of the back end; busy stays high
// while the front end works or holds a job for a full queue.
// Reset clears the used flags, the count, the free pointer and sets the
// table size to 256; entry contents stay undefined until written.
`timescale 1ns / 1ps
module coalesced_hash_table_insert_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cht_pkg::in_item_t     in_data,
  output logic                  out_valid,
  output cht_pkg::out_item_t    out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import cht_pkg::*;

  logic [SIZE_W-1:0] table_size_r;
  logic [CNT_W-1:0]  size_eff;
  logic              q_push, q_full, q_valid, q_pop;
  job_t              f_job, b_job;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(table_size_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_W'(256);
    end else if (cfg_wr) begin
      table_size_r <= pwdata[SIZE_W-1:0];
    end
  end

  // clamp the size into one to SLOTS
  always_comb begin
    if (table_size_r == '0) begin
      size_eff = CNT_W'(1);
    end else if ({{CNT_W{1'b0}}, table_size_r} > (CNT_W+SIZE_W)'(SLOTS)) begin
      size_eff = CNT_W'(SLOTS);
    end else begin
      size_eff = CNT_W'(table_size_r);
    end
  end

  cht_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .size    (size_eff),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_job   (f_job)
  );

  cht_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (f_job),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (b_job)
  );

  cht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size_eff),
    .q_valid   (q_valid),
    .q_job     (b_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.slot_index == '0 && !out_data.replaced)
    else $error("error result carries slot or replaced flag");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_FULL ||
                  out_data.status == ST_NO_LINK)
    else $error("undefined status code");

endmodule

[sim/tb_coalesced_hash_table_insert_unit.sv]
// Self-checking testbench for coalesced_hash_table_insert_unit: inserts keys,
// predicts status, slot and replace flag from a local copy of the table.
// Depends on cht_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module tb_coalesced_hash_table_insert_unit;
  import cht_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_data;
  logic               out_valid;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  coalesced_hash_table_insert_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Local copy of the table
  bit          used[SLOTS];
  logic [63:0] stored_key[SLOTS];
  int          stored_len[SLOTS];
  bit          has_link[SLOTS];
  int          link_to[SLOTS];
  int          entry_count = 0;
  int          free_ptr = 0;
  int          size_reg = 256;

  out_item_t   pending_results[$];
  logic [63:0] known_keys[$];
  int          known_lens[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          burst = 0;

  function automatic logic [63:0] len_mask(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [31:0] oaat_hash(logic [63:0] k, int n);
    logic [31:0] h;
    logic [31:0] b;
    h = '0;
    for (int i = 0; i < n; i++) begin
      b = {{24{k[8*i+7]}}, k[8*i +: 8]};
      h += b;
      h += h << 10;
      h ^= h >> 6;
    end
    h += h << 3;
    h ^= h >> 11;
    h += h << 15;
    return h;
  endfunction

  function automatic void place_entry(int s, logic [63:0] k, int n);
    used[s]       = 1'b1;
    stored_key[s] = k;
    stored_len[s] = n;
    has_link[s]   = 1'b0;
    link_to[s]    = 0;
    entry_count++;
  endfunction

  function automatic out_item_t predict_insert(in_item_t it);
    out_item_t   r;
    logic [63:0] k;
    int          n;
    int          sz;
    int          idx;
    r  = '0;
    n  = (it.key_length > 8) ? 8 : int'(it.key_length);
    k  = it.key_bytes & len_mask(n);
    sz = (size_reg == 0) ? 1 : ((size_reg > SLOTS) ? SLOTS : size_reg);
    if (entry_count >= sz) begin
      r.status = ST_FULL;
      return r;
    end
    idx = int'(oaat_hash(k, n) % 32'(sz));
    if (!used[idx]) begin
      place_entry(idx, k, n);
      if (idx == free_ptr)
        while (free_ptr < sz && used[free_ptr]) free_ptr++;
      r.status = ST_OK;
      r.slot_index = idx[7:0];
      return r;
    end
    for (int steps = 0; steps < SLOTS; steps++) begin
      if (stored_len[idx] == n && stored_key[idx] == k) begin
        r.status = ST_OK;
        r.slot_index = idx[7:0];
        r.replaced = 1'b1;
        return r;
      end
      if (!has_link[idx] || link_to[idx] >= SLOTS) break;
      idx = link_to[idx];
    end
    if (free_ptr >= sz) begin
      r.status = ST_NO_LINK;
      return r;
    end
    has_link[idx] = 1'b1;
    link_to[idx]  = free_ptr;
    r.slot_index  = free_ptr[7:0];
    place_entry(free_ptr, k, n);
    while (free_ptr < sz && used[free_ptr]) free_ptr++;
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.slot_index !== want.slot_index)
          report_mismatch("slot_index", out_data.slot_index, want.slot_index);
        if (out_data.replaced !== want.replaced)
          report_mismatch("replaced", out_data.replaced, want.replaced);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_insert(in_item_t it);
    while (!burst && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_insert(it));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_table_size(int v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_TABLE_SIZE);
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = v & 'h1FF;
  endtask

  function automatic in_item_t make_item(logic [63:0] k, int n, logic [31:0] v, int t);
    in_item_t it;
    it.key_bytes  = k;
    it.key_length = 4'(n);
    it.value_data = v;
    it.value_kind = 4'(t);
    return it;
  endfunction

  // Mostly reuse known keys (replacements), sometimes with junk above the length
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [63:0] junk;
    int          pick;
    int          n;
    junk = {$urandom, $urandom};
    it.value_data = $urandom;
    it.value_kind = 4'($urandom_range(15));
    if (known_keys.size() > 0 && $urandom_range(99) < 55) begin
      pick = $urandom_range(known_keys.size() - 1);
      n = known_lens[pick];
      it.key_bytes = known_keys[pick];
      if ($urandom_range(2) == 0) it.key_bytes |= junk & ~len_mask(n);
      it.key_length = (n == 8) ? 4'($urandom_range(8, 15)) : 4'(n);
    end else begin
      it.key_length = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(1, 8));
      it.key_bytes = junk;
      n = (it.key_length > 8) ? 8 : int'(it.key_length);
      known_keys.push_back(junk & len_mask(n));
      known_lens.push_back(n);
    end
    return it;
  endfunction

  task automatic test_size_extremes;
    write_table_size(0);
    send_insert(make_item(64'h41, 1, 32'h1, 1));
    send_insert(make_item(64'h41, 1, 32'h2, 2));
    send_insert(make_item(64'h42, 1, 32'h3, 3));
    drain();
    write_table_size(1);
    send_insert(make_item(64'h43, 1, 32'h4, 4));
    drain();
    write_table_size(3);
    repeat (6) send_insert(random_item());
    drain();
  endtask

  task automatic test_field_extremes;
    write_table_size(256);
    send_insert(make_item(64'h0, 0, 32'h0, 0));
    send_insert(make_item('1, 0, 32'hFFFF_FFFF, 15));
    send_insert(make_item('1, 8, 32'h1234_5678, 5));
    send_insert(make_item('1, 15, 32'h0, 9));
    send_insert(make_item(64'h80, 1, 32'hA5A5_A5A5, 3));
    send_insert(make_item(64'h7F, 1, 32'h5A5A_5A5A, 12));
    send_insert(make_item('1, 4, 32'h1, 6));
    send_insert(make_item(64'h0000_0000_FFFF_FFFF, 4, 32'h2, 7));
    send_insert(make_item(64'hFFFF_FFFF, 5, 32'h3, 8));
    send_insert(make_item(64'h8081_8283_8485_8687, 9, 32'h4, 10));
    send_insert(make_item(64'h8081_8283_8485_8687, 8, 32'h5, 11));
    send_insert(make_item(64'hDEAD_BEEF_0000_0000, 3, 32'h6, 14));
    drain();
  endtask

  task automatic test_random_phases;
    int sizes[14] = '{2, 8, 5, 20, 40, 31, 100, 64, 180, 256, 300, 511, 200, 256};
    foreach (sizes[p]) begin
      write_table_size(sizes[p]);
      burst = (p == 9);
      repeat (138) send_insert(random_item());
      drain();
    end
    burst = 0;
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    foreach (used[i]) used[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_size_extremes();
    test_field_extremes();
    test_random_phases();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hdl/cht_pkg.sv
hdl/cht_ram.sv
hdl/cht_front.sv
hdl/cht_queue.sv
hdl/cht_back.sv
hdl/coalesced_hash_table_insert_unit.sv
sim/tb_coalesced_hash_table_insert_unit.sv
